// File: design/vids_pkg.sv
// Shared types and constants for the vector integrate-and-dump scaler.
// Used by every module of the block except vids_ram; no dependencies.
package vids_pkg;

  localparam int VEC_MAX     = 1024;
  localparam int SAMPLE_BITS = 16;

  localparam int IDX_W   = (VEC_MAX > 1) ? $clog2(VEC_MAX) : 1;
  localparam int LEN_W   = $clog2(VEC_MAX + 1);
  localparam int SUM_W   = 32;
  localparam int DEC_W   = 17;
  localparam int VSEEN_W = 16;
  localparam int DEC_MAX = 65536;
  localparam int SCALE_W = 24;
  localparam int FRAC_W  = 16;
  localparam int PROD_W  = SUM_W + SCALE_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VEC_LEN    = 2'd0,
    REG_DECIMATION = 2'd1,
    REG_SCALE      = 2'd2
  } cfg_reg_t;

  // item leaving the accumulate stage
  typedef struct packed {
    logic             valid;
    logic             emit;
    logic [SUM_W-1:0] acc;
    logic [IDX_W-1:0] idx;
    logic             last;
  } sum_item_t;

  typedef struct packed {
    logic [SUM_W-1:0] scaled_sum;
    logic [IDX_W-1:0] idx;
    logic             last;
  } result_t;

endpackage

// File: design/vids_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// Read returns old data when reading and writing the same address.
module vids_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/vids_accum.sv
// Position/group sequencing and read-modify-write of the per-element sums.
// Depends on vids_pkg and vids_ram.
module vids_accum
  import vids_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [LEN_W-1:0]       vec_len,
  input  logic [DEC_W-1:0]       decimation,
  output sum_item_t              item
);

  logic [IDX_W-1:0]   position, position_next;
  logic [VSEEN_W-1:0] vectors_seen, vectors_seen_next;
  logic [LEN_W-1:0]   len_m1;
  logic [VSEEN_W-1:0] dec_m1;
  logic               end_vec, end_group;

  logic               s1_valid, s1_first, s1_emit, s1_last;
  logic [IDX_W-1:0]   s1_idx;
  logic [SUM_W-1:0]   s1_x;

  logic               wb_valid;
  logic [IDX_W-1:0]   wb_idx;
  logic [SUM_W-1:0]   wb_data;

  logic [SUM_W-1:0]   rdata, base, acc;

  always_comb begin
    if (vec_len == '0) begin
      len_m1 = '0;
    end else if (vec_len > LEN_W'(VEC_MAX)) begin
      len_m1 = LEN_W'(VEC_MAX - 1);
    end else begin
      len_m1 = vec_len - 1'b1;
    end

    if (decimation == '0) begin
      dec_m1 = '0;
    end else if (decimation > DEC_W'(DEC_MAX)) begin
      dec_m1 = VSEEN_W'(DEC_MAX - 1);
    end else begin
      dec_m1 = VSEEN_W'(decimation - 1'b1);
    end

    end_vec   = LEN_W'(position) >= len_m1;
    end_group = vectors_seen >= dec_m1;

    position_next     = position;
    vectors_seen_next = vectors_seen;
    if (accept) begin
      if (end_vec) begin
        position_next     = '0;
        vectors_seen_next = end_group ? '0 : vectors_seen + 1'b1;
      end else begin
        position_next = position + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position     <= '0;
      vectors_seen <= '0;
      s1_valid     <= 1'b0;
      wb_valid     <= 1'b0;
      item.valid   <= 1'b0;
    end else begin
      position     <= position_next;
      vectors_seen <= vectors_seen_next;
      s1_valid     <= accept;
      wb_valid     <= s1_valid;
      item.valid   <= s1_valid;
    end

    item.emit <= s1_emit;
    item.acc  <= acc;
    item.idx  <= s1_idx;
    item.last <= s1_last;
  end

  always_ff @(posedge clk) begin
    s1_idx   <= position;
    s1_first <= vectors_seen == '0;
    s1_emit  <= end_group;
    s1_last  <= end_vec;
    s1_x     <= {{(SUM_W-SAMPLE_BITS){sample[SAMPLE_BITS-1]}}, sample};

    wb_idx  <= s1_idx;
    wb_data <= acc;
  end

  // The read for this item happened on the same edge as the previous
  // item's write, so a hit on that entry takes the written value instead.
  always_comb begin
    base = (wb_valid && wb_idx == s1_idx) ? wb_data : rdata;
    acc  = s1_first ? s1_x : base + s1_x;
  end

  vids_ram #(
    .WIDTH (SUM_W),
    .DEPTH (VEC_MAX)
  ) u_sum_ram (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_idx),
    .wdata (acc),
    .raddr (position),
    .rdata (rdata)
  );

endmodule

// File: design/vids_scale.sv
// Gain stage: magnitude, Q8.16 multiply, truncating shift and saturation.
// Depends on vids_pkg.
module vids_scale
  import vids_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  sum_item_t          item,
  input  logic [SCALE_W-1:0] scale,
  output logic               push,
  output logic               drop,
  output result_t            res
);

  logic               s2_valid, s2_emit, s2_neg, s2_last;
  logic [SUM_W-1:0]   s2_mag;
  logic [IDX_W-1:0]   s2_idx;

  logic               s3_valid, s3_emit, s3_neg, s3_last;
  logic [PROD_W-1:0]  s3_prod;
  logic [IDX_W-1:0]   s3_idx;

  logic [PROD_W-FRAC_W-1:0] q;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s2_valid <= item.valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_emit <= item.emit;
    s2_neg  <= item.acc[SUM_W-1];
    s2_mag  <= item.acc[SUM_W-1] ? '0 - item.acc : item.acc;
    s2_idx  <= item.idx;
    s2_last <= item.last;

    s3_emit <= s2_emit;
    s3_neg  <= s2_neg;
    s3_prod <= PROD_W'(s2_mag) * PROD_W'(scale);
    s3_idx  <= s2_idx;
    s3_last <= s2_last;
  end

  // shifting the magnitude truncates toward zero for both signs
  always_comb begin
    q = s3_prod[PROD_W-1:FRAC_W];
    if (s3_neg) begin
      if (q >= (PROD_W-FRAC_W)'(33'h0_8000_0000)) begin
        res.scaled_sum = {1'b1, {(SUM_W-1){1'b0}}};
      end else begin
        res.scaled_sum = '0 - q[SUM_W-1:0];
      end
    end else begin
      if (q > (PROD_W-FRAC_W)'(33'h0_7FFF_FFFF)) begin
        res.scaled_sum = {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
        res.scaled_sum = q[SUM_W-1:0];
      end
    end
    res.idx  = s3_idx;
    res.last = s3_last;
    push     = s3_valid && s3_emit;
    drop     = s3_valid && !s3_emit;
  end

endmodule

// File: design/vids_fifo.sv
// Result queue in front of the output port; head is shown directly.
// Depends on vids_pkg.
module vids_fifo
  import vids_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t wdata,
  input  logic    pop,
  output logic    not_empty,
  output result_t head
);

  result_t            entries [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;

  assign not_empty = count != '0;
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

endmodule

// File: design/vector_integrate_dump_scale_top.sv
// Top level of the vector integrate-and-dump scaler.
// Depends on vids_pkg, vids_accum, vids_scale and vids_fifo.
//
// Samples come in on in_valid/in_stall/sample, one vector element per
// transfer; vec_len elements make a vector. Each element is summed over
// decimation consecutive vectors in a 1024 x 32 sum RAM (read, add, write
// back, with a bypass for back-to-back hits on one entry). During the last
// vector of a group every element's sum leaves on out_valid/out_stall as
// scaled_sum = sat32((sum * scale) >> 16), shifting the magnitude so it
// truncates toward zero, with element_index and vector_last. Other samples
// produce no output. Throughput: one sample per cycle while in_stall is
// low. Each sample passes the sum RAM read on the transfer edge, then
// add/write back, magnitude, multiply, saturate into the result queue.
// At most 8 samples may be in flight or queued; in_stall rises when that
// credit is used up, so a stalled receiver backs up into in_stall and
// nothing is lost. Reset clears the element position, vector count and
// queue, and loads vec_len = 1024, decimation = 1, scale = 1.0. The sum
// RAM is not cleared: the first vector of each group overwrites it.
// Registers are written on cfg_valid/cfg_ready (always ready); the user
// must write them only while idle; the block itself does not enforce it.
module vector_integrate_dump_scale_top
  import vids_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [SUM_W-1:0]       scaled_sum,
  output logic [IDX_W-1:0]       element_index,
  output logic                   vector_last,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [LEN_W-1:0]   vec_len;
  logic [DEC_W-1:0]   decimation;
  logic [SCALE_W-1:0] scale;

  logic             accept, pop, push, drop;
  logic [CNT_W-1:0] pending;
  sum_item_t        item;
  result_t          res, head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vec_len    <= LEN_W'(VEC_MAX);
      decimation <= DEC_W'(1);
      scale      <= SCALE_W'(65536);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_VEC_LEN:    vec_len    <= cfg_data[LEN_W-1:0];
        REG_DECIMATION: decimation <= cfg_data[DEC_W-1:0];
        REG_SCALE:      scale      <= cfg_data[SCALE_W-1:0];
        default:        ;
      endcase
    end
  end

  // credit: samples accepted and not yet delivered or discarded
  assign in_stall = pending >= CNT_W'(FIFO_DEPTH);
  assign accept   = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + CNT_W'(accept) - CNT_W'(pop) - CNT_W'(drop);
    end
  end

  vids_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .sample     (sample),
    .vec_len    (vec_len),
    .decimation (decimation),
    .item       (item)
  );

  vids_scale u_scale (
    .clk   (clk),
    .rst   (rst),
    .item  (item),
    .scale (scale),
    .push  (push),
    .drop  (drop),
    .res   (res)
  );

  vids_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wdata     (res),
    .pop       (pop),
    .not_empty (out_valid),
    .head      (head)
  );

  assign scaled_sum    = head.scaled_sum;
  assign element_index = head.idx;
  assign vector_last   = head.last;

endmodule
